FILE: rtl/dslfo_pkg.sv
package dslfo_pkg;

	// Default elaboration values for the top level
	localparam int unsigned DEF_QUARTER_TABLE_SIZE = 32;
	localparam int unsigned DEF_PHASE_BITS         = 24;

	// Points of the base quarter-wave table (entries 0..BASE_POINTS)
	localparam int unsigned BASE_POINTS = 32;

	// Constant divisors, 7 bits each
	localparam logic [6:0] SINE_PEAK = 7'd127;
	// 256000 = 2^11 * 125: the power of two folds into the phase scaling
	localparam logic [6:0] RATE_DIV   = 7'd125;
	localparam int unsigned RATE_SHIFT = 11;

	// Largest output magnitude: 127 * 65535 * 255 / 127
	localparam logic [31:0] MAX_MAG = 32'd16711425;

	// Configuration register indexes
	localparam logic [1:0] REG_DEPTH = 2'd0;
	localparam logic [1:0] REG_RANGE = 2'd1;
	localparam logic [1:0] REG_SPEED = 2'd2;
	localparam logic [1:0] REG_DELAY = 2'd3;

	// Reset values of the configuration registers
	localparam logic [15:0] RST_DEPTH = 16'd0;
	localparam logic [7:0]  RST_RANGE = 8'd1;
	localparam logic [15:0] RST_SPEED = 16'd1600;
	localparam logic [15:0] RST_DELAY = 16'd0;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DELAY,
		ST_MUL_RATE,
		ST_DIV_RATE,
		ST_PHASE_ADD,
		ST_INDEX,
		ST_LOOKUP,
		ST_MUL_DEPTH,
		ST_MUL_SINE,
		ST_DIV_PEAK,
		ST_DONE
	} dslfo_state_t;

	// Quarter-wave sine, peak 127, 33 points
	function automatic logic [6:0] base_quarter(input int unsigned k);
		case (k)
			0:  return 7'd0;
			1:  return 7'd6;
			2:  return 7'd12;
			3:  return 7'd19;
			4:  return 7'd25;
			5:  return 7'd31;
			6:  return 7'd37;
			7:  return 7'd43;
			8:  return 7'd49;
			9:  return 7'd54;
			10: return 7'd60;
			11: return 7'd65;
			12: return 7'd71;
			13: return 7'd76;
			14: return 7'd81;
			15: return 7'd85;
			16: return 7'd90;
			17: return 7'd94;
			18: return 7'd98;
			19: return 7'd102;
			20: return 7'd106;
			21: return 7'd109;
			22: return 7'd112;
			23: return 7'd115;
			24: return 7'd117;
			25: return 7'd120;
			26: return 7'd122;
			27: return 7'd123;
			28: return 7'd125;
			29: return 7'd126;
			30: return 7'd126;
			31: return 7'd127;
			default: return 7'd127;
		endcase
	endfunction

endpackage

FILE: rtl/delayed_sine_lfo.sv
// Channel   Handshake             Payload                     Direction
// in        in_valid / in_ready   op, elapsed_ms              into block
// out       out_valid / out_ready lfo_value                   out of block
// cfg       cfg_we                cfg_index, cfg_data         into block
//
// One transaction at a time. A restart, or an advance that stays inside the start
// delay, skips the rate multiply and the rate divide; an advance that moves the
// phase runs both. A silent result (depth zero or delay still running) skips
// the depth and sine multiplies and the peak divide. The datapath is a bit-serial
// shift-add multiplier and a bit-serial divider by a constant (16 + 8 + 7 multiply
// steps, PHASE_BITS + 21 and 32 divide steps).
// arst_n clears phase, delay count, state and configuration at once.
// A new input transaction is taken while a finished result waits in the output register;
// the next result then stays in its last state until that register is free.
module delayed_sine_lfo import dslfo_pkg::*; #(
	parameter int unsigned QUARTER_TABLE_SIZE = DEF_QUARTER_TABLE_SIZE,
	parameter int unsigned PHASE_BITS         = DEF_PHASE_BITS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               op,
	input  logic [15:0]        elapsed_ms,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [24:0] lfo_value,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data
);

	localparam int unsigned POINTS  = 4 * QUARTER_TABLE_SIZE;
	localparam int unsigned IDX_W   = $clog2(POINTS);
	localparam int unsigned J_W     = $clog2(QUARTER_TABLE_SIZE + 1);
	localparam int unsigned PROD_W  = PHASE_BITS + 11;
	localparam int unsigned CNT_W   = $clog2(PHASE_BITS + 21);
	localparam int unsigned RATE_STEPS = 32 + PHASE_BITS - RATE_SHIFT;

	// Quadrant bounds, one bit wider than the index
	localparam logic [IDX_W:0] Q1 = (IDX_W + 1)'(QUARTER_TABLE_SIZE);
	localparam logic [IDX_W:0] Q2 = (IDX_W + 1)'(2 * QUARTER_TABLE_SIZE);
	localparam logic [IDX_W:0] Q3 = (IDX_W + 1)'(3 * QUARTER_TABLE_SIZE);
	localparam logic [IDX_W:0] Q4 = (IDX_W + 1)'(4 * QUARTER_TABLE_SIZE);

	dslfo_state_t state_q, state_d;

	// configuration
	logic [15:0] depth_q;
	logic [7:0]  range_q;
	logic [15:0] speed_q;
	logic [15:0] delay_q;

	// oscillator state
	logic [PHASE_BITS-1:0] phase_q;
	logic [15:0]           de_q;

	// datapath
	logic              op_q;
	logic [15:0]       ms_q;
	logic [31:0]       acc_q;
	logic [31:0]       mc_q;
	logic [15:0]       mp_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [6:0]        rem_q;
	logic [31:0]       quo_q;
	logic [IDX_W-1:0]  idx_q;
	logic              silent_q;
	logic [6:0]        mag_q;
	logic              neg_q;
	logic              out_valid_q;
	logic [24:0]       lfo_q;

	logic        out_load;
	logic [16:0] delay_sum;
	logic        delay_run;
	logic        delay_hold;
	logic [15:0] ms_eff;
	logic [31:0] mul_sum;
	logic        div_bit;
	logic [6:0]  div_d;
	logic [7:0]  div_t;
	logic        div_ge;
	logic [6:0]  rem_next;
	logic [31:0] quo_next;
	logic [PROD_W-1:0] idx_prod;
	logic [IDX_W:0]    idx_x;
	logic [J_W-1:0]    tab_j;
	logic              tab_neg;
	logic [6:0]        qtab [0:QUARTER_TABLE_SIZE];
	logic [24:0]       quo_out;

	// Quarter table resampled to QUARTER_TABLE_SIZE + 1 points, nearest base entry
	for (genvar gj = 0; gj <= QUARTER_TABLE_SIZE; gj++) begin : g_qtab
		localparam int unsigned KRAW =
			(gj * BASE_POINTS + QUARTER_TABLE_SIZE / 2) / QUARTER_TABLE_SIZE;
		localparam int unsigned KSEL = (KRAW > BASE_POINTS) ? BASE_POINTS : KRAW;
		assign qtab[gj] = base_quarter(KSEL);
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= RST_DEPTH;
			range_q <= RST_RANGE;
			speed_q <= RST_SPEED;
			delay_q <= RST_DELAY;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DEPTH: depth_q <= cfg_data;
				REG_RANGE: range_q <= cfg_data[7:0];
				REG_SPEED: speed_q <= cfg_data;
				REG_DELAY: delay_q <= cfg_data;
				default:   ;
			endcase
		end
	end

	// Start-delay bookkeeping: time first fills the delay, the rest moves the phase
	assign delay_sum  = {1'b0, de_q} + {1'b0, ms_q};
	assign delay_run  = de_q < delay_q;
	assign delay_hold = delay_run && (delay_sum <= {1'b0, delay_q});
	assign ms_eff     = delay_run ? 16'(delay_sum - {1'b0, delay_q}) : ms_q;

	// Shift-add multiplier step
	assign mul_sum = acc_q + (mp_q[0] ? mc_q : 32'd0);

	// Restoring divider step by a 7-bit constant, dividend MSB first
	assign div_bit  = (cnt_q < CNT_W'(32)) ? acc_q[31] : 1'b0;
	assign div_d    = (state_q == ST_DIV_RATE) ? RATE_DIV : SINE_PEAK;
	assign div_t    = {rem_q, div_bit};
	assign div_ge   = div_t >= {1'b0, div_d};
	assign rem_next = div_ge ? 7'(div_t - {1'b0, div_d}) : div_t[6:0];
	assign quo_next = {quo_q[30:0], div_ge};

	// Table index from the phase
	assign idx_prod = PROD_W'(phase_q) * PROD_W'(POINTS);

	// Quadrant folding
	assign idx_x = {1'b0, idx_q};
	always_comb begin
		tab_neg = 1'b0;
		if (idx_x < Q1) begin
			tab_j = J_W'(idx_x);
		end else if (idx_x < Q2) begin
			tab_j = J_W'(Q2 - idx_x);
		end else if (idx_x < Q3) begin
			tab_j   = J_W'(idx_x - Q2);
			tab_neg = 1'b1;
		end else begin
			tab_j   = J_W'(Q4 - idx_x);
			tab_neg = 1'b1;
		end
	end

	assign quo_out = quo_q[24:0];

	// Next state and handshake
	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		out_load = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = ST_DELAY;
				end
			end
			ST_DELAY: begin
				if (op_q || delay_hold) begin
					state_d = ST_INDEX;
				end else begin
					state_d = ST_MUL_RATE;
				end
			end
			ST_MUL_RATE: begin
				if (cnt_q == CNT_W'(15)) begin
					state_d = ST_DIV_RATE;
				end
			end
			ST_DIV_RATE: begin
				if (cnt_q == CNT_W'(RATE_STEPS - 1)) begin
					state_d = ST_PHASE_ADD;
				end
			end
			ST_PHASE_ADD: state_d = ST_INDEX;
			ST_INDEX:     state_d = ST_LOOKUP;
			ST_LOOKUP: begin
				state_d = silent_q ? ST_DONE : ST_MUL_DEPTH;
			end
			ST_MUL_DEPTH: begin
				if (cnt_q == CNT_W'(7)) begin
					state_d = ST_MUL_SINE;
				end
			end
			ST_MUL_SINE: begin
				if (cnt_q == CNT_W'(6)) begin
					state_d = ST_DIV_PEAK;
				end
			end
			ST_DIV_PEAK: begin
				if (cnt_q == CNT_W'(31)) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Control state, phase and delay count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			phase_q     <= '0;
			de_q        <= '0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == ST_DELAY) begin
				if (op_q) begin
					phase_q <= '0;
					de_q    <= '0;
				end else if (delay_hold) begin
					de_q <= delay_sum[15:0];
				end else if (delay_run) begin
					de_q <= delay_q;
				end
			end
			if (state_q == ST_PHASE_ADD) begin
				phase_q <= phase_q + quo_q[PHASE_BITS-1:0];
			end
		end
	end

	// Serial datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					op_q <= op;
					ms_q <= elapsed_ms;
				end
			end
			ST_DELAY: begin
				acc_q <= '0;
				mc_q  <= {16'd0, speed_q};
				mp_q  <= ms_eff;
				cnt_q <= '0;
			end
			ST_MUL_RATE: begin
				acc_q <= mul_sum;
				mc_q  <= {mc_q[30:0], 1'b0};
				mp_q  <= {1'b0, mp_q[15:1]};
				rem_q <= '0;
				cnt_q <= (cnt_q == CNT_W'(15)) ? '0 : cnt_q + CNT_W'(1);
			end
			ST_DIV_RATE, ST_DIV_PEAK: begin
				acc_q <= {acc_q[30:0], 1'b0};
				rem_q <= rem_next;
				quo_q <= quo_next;
				cnt_q <= cnt_q + CNT_W'(1);
			end
			ST_PHASE_ADD: ;
			ST_INDEX: begin
				idx_q    <= idx_prod[PHASE_BITS +: IDX_W];
				silent_q <= (depth_q == 16'd0) || (de_q < delay_q);
			end
			ST_LOOKUP: begin
				mag_q <= qtab[tab_j];
				neg_q <= tab_neg;
				acc_q <= '0;
				mc_q  <= {16'd0, depth_q};
				mp_q  <= {8'd0, range_q};
				cnt_q <= '0;
				quo_q <= '0;
			end
			ST_MUL_DEPTH: begin
				if (cnt_q == CNT_W'(7)) begin
					acc_q <= '0;
					mc_q  <= mul_sum;
					mp_q  <= {9'd0, mag_q};
					cnt_q <= '0;
				end else begin
					acc_q <= mul_sum;
					mc_q  <= {mc_q[30:0], 1'b0};
					mp_q  <= {1'b0, mp_q[15:1]};
					cnt_q <= cnt_q + CNT_W'(1);
				end
			end
			ST_MUL_SINE: begin
				acc_q <= mul_sum;
				mc_q  <= {mc_q[30:0], 1'b0};
				mp_q  <= {1'b0, mp_q[15:1]};
				rem_q <= '0;
				cnt_q <= (cnt_q == CNT_W'(6)) ? '0 : cnt_q + CNT_W'(1);
			end
			ST_DONE: begin
				if (out_load) begin
					lfo_q <= neg_q ? 25'(-quo_out) : quo_out;
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign lfo_value = signed'(lfo_q);

	// Checks
	a_in_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while a transaction is in progress");

	a_rate_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV_RATE |-> rem_q < RATE_DIV)
		else $error("rate divider remainder out of range");

	a_peak_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV_PEAK |-> rem_q < SINE_PEAK)
		else $error("peak divider remainder out of range");

	a_mag_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DONE |-> quo_q <= MAX_MAG)
		else $error("output magnitude above full scale");

endmodule

FILE: verif/dslfo_tb_pkg.sv
package dslfo_tb_pkg;

	// Operation carried by an input transaction
	typedef enum logic {
		OP_ADVANCE = 1'b0,
		OP_RESTART = 1'b1
	} lfo_op_t;

endpackage

FILE: verif/dslfo_checker.sv
module dslfo_checker
	import dslfo_pkg::*;
	import dslfo_tb_pkg::*;
#(
	parameter int unsigned QUARTER_TABLE_SIZE = DEF_QUARTER_TABLE_SIZE,
	parameter int unsigned PHASE_BITS         = DEF_PHASE_BITS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic               op,
	input  logic [15:0]        elapsed_ms,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic signed [24:0] lfo_value,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	output int                 fail_count,
	output int                 pending
);

	localparam longint unsigned MS_RATE_DIV = 64'd256000;
	localparam int unsigned     REPORT_MAX  = 10;

	// Quarter-wave sine, peak 127; entry 0 is the rightmost element
	localparam logic [32:0][6:0] SINE_QTR = {
		7'd127, 7'd127, 7'd126, 7'd126, 7'd125, 7'd123, 7'd122, 7'd120, 7'd117,
		7'd115, 7'd112, 7'd109, 7'd106, 7'd102, 7'd98,  7'd94,  7'd90,  7'd85,
		7'd81,  7'd76,  7'd71,  7'd65,  7'd60,  7'd54,  7'd49,  7'd43,  7'd37,
		7'd31,  7'd25,  7'd19,  7'd12,  7'd6,   7'd0
	};

	// Shadow copy of configuration and oscillator state
	logic [15:0]           depth_q;
	logic [7:0]            range_q;
	logic [15:0]           speed_q;
	logic [15:0]           delay_q;
	logic [PHASE_BITS-1:0] phase_acc;
	logic [15:0]           delay_spent;

	// Expected lfo values, oldest first
	logic signed [24:0] lfo_due_q [$];

	// Quarter table resampled to the configured size
	function automatic int unsigned qtr_sine(input int unsigned j);
		int unsigned k;
		k = (j * BASE_POINTS + QUARTER_TABLE_SIZE / 2) / QUARTER_TABLE_SIZE;
		if (k > BASE_POINTS)
			k = BASE_POINTS;
		return int'(SINE_QTR[k]);
	endfunction

	// Apply one transaction to the shadow state and return the lfo value after it
	task automatic lfo_step(input logic op_i, input logic [15:0] ms_i,
	                        output logic signed [24:0] value_o);
		logic [16:0]     spent_sum;
		logic [15:0]     ms;
		logic            moving;
		logic [63:0]     inc;
		longint unsigned idx;
		int unsigned     q;
		logic [63:0]     mag;
		logic            neg;
		q = QUARTER_TABLE_SIZE;
		if (op_i == OP_RESTART) begin
			phase_acc   = '0;
			delay_spent = '0;
		end else begin
			ms     = ms_i;
			moving = 1'b1;
			// start delay absorbs time first
			if (delay_spent < delay_q) begin
				spent_sum = {1'b0, delay_spent} + {1'b0, ms};
				if (spent_sum <= {1'b0, delay_q}) begin
					delay_spent = spent_sum[15:0];
					moving      = 1'b0;
				end else begin
					ms          = ms - (delay_q - delay_spent);
					delay_spent = delay_q;
				end
			end
			if (moving) begin
				inc       = ((64'(speed_q) * 64'(ms)) << PHASE_BITS) / MS_RATE_DIV;
				phase_acc = phase_acc + inc[PHASE_BITS-1:0];
			end
		end

		if (depth_q == '0 || delay_spent < delay_q) begin
			value_o = '0;
		end else begin
			idx = (64'(phase_acc) * 64'(4 * q)) >> PHASE_BITS;
			neg = 1'b0;
			if (idx < q) begin
				mag = qtr_sine(int'(idx));
			end else if (idx < 2 * q) begin
				mag = qtr_sine(int'(2 * q - idx));
			end else if (idx < 3 * q) begin
				mag = qtr_sine(int'(idx - 2 * q));
				neg = 1'b1;
			end else if (idx < 4 * q) begin
				mag = qtr_sine(int'(4 * q - idx));
				neg = 1'b1;
			end else begin
				mag = '0;
			end
			mag = (mag * 64'(depth_q) * 64'(range_q)) / 64'(SINE_PEAK);
			if (neg)
				mag = 64'd0 - mag;
			value_o = mag[24:0];
		end
	endtask

	// Compare results, track configuration, predict on each accepted transaction
	always @(posedge clk or negedge arst_n) begin
		logic signed [24:0] due;
		if (!arst_n) begin
			depth_q     = RST_DEPTH;
			range_q     = RST_RANGE;
			speed_q     = RST_SPEED;
			delay_q     = RST_DELAY;
			phase_acc   = '0;
			delay_spent = '0;
			lfo_due_q.delete();
			fail_count  = 0;
			pending     = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (lfo_due_q.size() == 0) begin
					fail_count++;
					if (fail_count <= REPORT_MAX)
						$display("unexpected result transaction: lfo_value %0d", lfo_value);
				end else begin
					due = lfo_due_q.pop_front();
					if (lfo_value !== due) begin
						fail_count++;
						if (fail_count <= REPORT_MAX)
							$display("lfo_value mismatch: expected %0d, got %0d", due, lfo_value);
					end
				end
			end

			if (cfg_we) begin
				case (cfg_index)
					REG_DEPTH: depth_q = cfg_data;
					REG_RANGE: range_q = cfg_data[7:0];
					REG_SPEED: speed_q = cfg_data;
					REG_DELAY: delay_q = cfg_data;
					default: ;
				endcase
			end

			if (in_valid && in_ready) begin
				lfo_step(op, elapsed_ms, due);
				lfo_due_q.push_back(due);
			end
			pending = lfo_due_q.size();
		end
	end

endmodule

FILE: verif/tb_delayed_sine_lfo.sv
module tb_delayed_sine_lfo;
	import dslfo_pkg::*;
	import dslfo_tb_pkg::*;

	localparam int unsigned CYCLE_LIMIT   = 500000;
	localparam int unsigned SETTLE_CYCLES = 8;
	localparam int unsigned DRAIN_CYCLES  = 150;
	localparam int unsigned RAND_PHASES   = 6;
	localparam int unsigned PHASE_ITEMS   = 75;

	logic               clk         = 1'b0;
	logic               arst_n      = 1'b0;
	logic               in_valid    = 1'b0;
	logic               in_ready;
	logic               op          = 1'b0;
	logic [15:0]        elapsed_ms  = '0;
	logic               out_valid;
	logic               out_ready   = 1'b0;
	logic signed [24:0] lfo_value;
	logic               cfg_we      = 1'b0;
	logic [1:0]         cfg_index   = '0;
	logic [15:0]        cfg_data    = '0;

	int    fail_count;
	int    pending;
	int    cycle_cnt = 0;
	logic  stall_on  = 1'b1;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	delayed_sine_lfo dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.op         (op),
		.elapsed_ms (elapsed_ms),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.lfo_value  (lfo_value),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	dslfo_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.op         (op),
		.elapsed_ms (elapsed_ms),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.lfo_value  (lfo_value),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// Receiver backpressure
	always @(negedge clk) begin
		out_ready <= stall_on ? ($urandom_range(99) >= 23) : 1'b1;
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// All tasks are entered and left at a falling edge
	task automatic send_txn(input lfo_op_t kind, input logic [15:0] ms);
		while (stall_on && $urandom_range(99) < 23) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid   <= 1'b1;
		op         <= kind;
		elapsed_ms <= ms;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
	endtask

	// Write all four registers once the block is idle
	task automatic load_regs(input logic [15:0] dep, input logic [7:0] rng,
	                         input logic [15:0] spd, input logic [15:0] dly);
		wait_drained();
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= REG_DEPTH;
		cfg_data  <= dep;
		@(negedge clk);
		cfg_index <= REG_RANGE;
		cfg_data  <= {8'($urandom), rng};
		@(negedge clk);
		cfg_index <= REG_SPEED;
		cfg_data  <= spd;
		@(negedge clk);
		cfg_index <= REG_DELAY;
		cfg_data  <= dly;
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	// Zero, all ones, or anything
	function automatic logic [15:0] pick_word();
		case ($urandom_range(3))
			0:       return 16'h0000;
			1:       return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	initial begin
		int unsigned ph;
		int unsigned n;
		logic [15:0] r_depth;
		logic [15:0] r_speed;
		logic [15:0] r_delay;
		logic [7:0]  r_range;
		logic [15:0] r_ms;
		lfo_op_t     r_op;

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset values: depth 0 keeps output silent
		send_txn(OP_RESTART, 16'hFFFF);
		send_txn(OP_ADVANCE, 16'd0);
		send_txn(OP_ADVANCE, 16'hFFFF);

		// largest settings, no delay
		load_regs(16'hFFFF, 8'd255, 16'hFFFF, 16'd0);
		send_txn(OP_RESTART, 16'd0);
		send_txn(OP_ADVANCE, 16'd1);
		send_txn(OP_ADVANCE, 16'd3);
		send_txn(OP_ADVANCE, 16'hFFFF);
		send_txn(OP_ADVANCE, 16'd0);

		// 6.25 Hz: 40 ms per quadrant; delay filled exactly, then crossed
		load_regs(16'd4096, 8'd1, 16'd1600, 16'd100);
		send_txn(OP_RESTART, 16'd0);
		send_txn(OP_ADVANCE, 16'd50);
		send_txn(OP_ADVANCE, 16'd50);
		send_txn(OP_ADVANCE, 16'd20);
		send_txn(OP_ADVANCE, 16'd20);
		send_txn(OP_RESTART, 16'd7);
		send_txn(OP_ADVANCE, 16'd130);
		send_txn(OP_ADVANCE, 16'd40);
		send_txn(OP_ADVANCE, 16'd40);

		// delay lowered below the spent count counts as finished
		load_regs(16'd4096, 8'd1, 16'd1600, 16'd20);
		send_txn(OP_ADVANCE, 16'd10);

		// delay raised after finishing: silent until the count catches up
		load_regs(16'd4096, 8'd1, 16'd1600, 16'd200);
		send_txn(OP_ADVANCE, 16'd50);
		send_txn(OP_ADVANCE, 16'd60);

		// zero range and zero speed
		load_regs(16'hFFFF, 8'd0, 16'd0, 16'd0);
		send_txn(OP_ADVANCE, 16'hFFFF);

		// random phases; one of them runs without stalls
		for (ph = 0; ph < RAND_PHASES; ph++) begin
			r_depth = pick_word();
			r_speed = pick_word();
			case ($urandom_range(3))
				0:       r_range = 8'd0;
				1:       r_range = 8'd255;
				2:       r_range = 8'd1;
				default: r_range = 8'($urandom);
			endcase
			case ($urandom_range(3))
				0:       r_delay = 16'd0;
				1:       r_delay = 16'($urandom_range(1, 300));
				2:       r_delay = 16'($urandom_range(1, 5000));
				default: r_delay = pick_word();
			endcase
			load_regs(r_depth, r_range, r_speed, r_delay);
			stall_on = (ph != 2);
			for (n = 0; n < PHASE_ITEMS; n++) begin
				if (n == 40)
					wait_drained();
				r_op = ($urandom_range(9) == 0) ? OP_RESTART : OP_ADVANCE;
				case ($urandom_range(7))
					0:       r_ms = 16'd0;
					1:       r_ms = 16'hFFFF;
					2, 3:    r_ms = 16'($urandom);
					default: r_ms = 16'($urandom_range(1, 80));
				endcase
				send_txn(r_op, r_ms);
			end
		end
		stall_on = 1'b1;

		wait_drained();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

FILE: delayed_sine_lfo.f
rtl/dslfo_pkg.sv
rtl/delayed_sine_lfo.sv
verif/dslfo_tb_pkg.sv
verif/dslfo_checker.sv
verif/tb_delayed_sine_lfo.sv
